/* rtl/core/pfa_pkg.sv */
// Package for the page-frame allocator: payload structs, op and status codes,
// controller state and controller/datapath command and status groups.
// No dependencies.
package pfa_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_SEED  = 3'd2,
      OP_UP    = 3'd3,
      OP_DOWN  = 3'd4,
      OP_QUERY = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_BAD   = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [13:0] frame;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [13:0] alloc_frame;
      logic [7:0]  ref_count;
      logic [14:0] free_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_CLEAR = 2'd0,
      S_IDLE  = 2'd1,
      S_EXEC  = 2'd2
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // zero one count entry
      logic launch;      // latch request, issue memory reads
      logic execute;     // update memories, register result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;  // final count entry being zeroed
   } stat_type;

endpackage

/* rtl/core/pfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/pfa_ctrl.sv */
// Allocator controller: clearing pass after reset, then launch/execute sequence.
// Depends on pfa_pkg.
module pfa_ctrl
   import pfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.launch = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/pfa_datapath.sv */
// Allocator datapath: count memory, free stack memory, free total, kernel-end
// register and result register. Depends on pfa_pkg and pfa_ram.
module pfa_datapath
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES = 16384,
   parameter int COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [13:0] csr_wdata,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int TOT_W = $clog2(NUM_FRAMES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [13:0]       kernel_end_ff;
   logic [TOT_W-1:0]  free_total_ff, free_total_in;
   logic [IDX_W-1:0]  clear_addr_ff;
   logic [2:0]        op_ff;
   logic [13:0]       frame_ff;
   logic              strobe_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0] cnt_rd;
   logic [13:0]           stk_rd;

   // count memory ports
   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  ex_cnt_we;
   logic [IDX_W-1:0]      ex_cnt_addr;
   logic [COUNT_BITS-1:0] ex_cnt_data;
   // stack memory ports
   logic                  stk_we;
   logic [IDX_W-1:0]      stk_raddr;

   logic                  in_table, got_in_table, below_kernel, empty, full;
   logic [COUNT_BITS-1:0] cnt_new;
   status_type            status;

   assign stat.clear_last = (clear_addr_ff == IDX_W'(NUM_FRAMES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff <= '0;
         free_total_ff <= '0;
         clear_addr_ff <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            kernel_end_ff <= csr_wdata;
         end
         if (cmd.clear_step) begin
            clear_addr_ff <= clear_addr_ff + IDX_W'(1);
         end
         free_total_ff <= free_total_in;
         strobe_ff     <= cmd.execute;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.launch) begin
         op_ff    <= req_data.op;
         frame_ff <= req_data.frame;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // top of stack sits one below the free total
   assign stk_raddr = IDX_W'(free_total_ff - TOT_W'(1));

   assign in_table     = 32'(frame_ff) < 32'(NUM_FRAMES);
   assign got_in_table = 32'(stk_rd) < 32'(NUM_FRAMES);
   assign below_kernel = frame_ff < kernel_end_ff;
   assign empty        = (free_total_ff == '0);
   assign full         = (free_total_ff == TOT_W'(NUM_FRAMES));

   always_comb begin
      status        = STAT_OK;
      free_total_in = free_total_ff;
      ex_cnt_we     = 1'b0;
      ex_cnt_addr   = IDX_W'(frame_ff);
      ex_cnt_data   = cnt_rd;
      stk_we        = 1'b0;
      cnt_new       = '0;
      rsp_in        = '0;
      case (op_ff)
         OP_ALLOC: begin
            if (empty) begin
               status = STAT_EMPTY;
            end else begin
               free_total_in      = free_total_ff - TOT_W'(1);
               ex_cnt_we          = got_in_table;
               ex_cnt_addr        = IDX_W'(stk_rd);
               ex_cnt_data        = COUNT_BITS'(1);
               cnt_new            = COUNT_BITS'(1);
               rsp_in.alloc_frame = stk_rd;
            end
         end
         OP_FREE, OP_SEED: begin
            if (!in_table || below_kernel) begin
               status = STAT_BAD;
            end else begin
               if (op_ff == OP_SEED) begin
                  cnt_new = '0;
               end else if (cnt_rd != '0) begin
                  cnt_new = cnt_rd - COUNT_BITS'(1);
               end else begin
                  cnt_new = cnt_rd;
               end
               ex_cnt_we   = 1'b1;
               ex_cnt_data = cnt_new;
               if (cnt_new == '0) begin
                  if (full) begin
                     status = STAT_FULL;
                  end else begin
                     stk_we        = 1'b1;
                     free_total_in = free_total_ff + TOT_W'(1);
                  end
               end
            end
         end
         OP_UP, OP_DOWN, OP_QUERY: begin
            if (!in_table) begin
               status = STAT_BAD;
            end else begin
               cnt_new = cnt_rd;
               if (op_ff == OP_UP && cnt_rd != COUNT_MAX) begin
                  cnt_new = cnt_rd + COUNT_BITS'(1);
               end else if (op_ff == OP_DOWN && cnt_rd != '0) begin
                  cnt_new = cnt_rd - COUNT_BITS'(1);
               end
               ex_cnt_we   = 1'b1;
               ex_cnt_data = cnt_new;
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
      if (!cmd.execute) begin
         free_total_in = free_total_ff;
         ex_cnt_we     = 1'b0;
         stk_we        = 1'b0;
      end
      rsp_in.status     = status;
      rsp_in.ref_count  = 8'(cnt_new);
      rsp_in.free_count = 15'(free_total_in);
   end

   // clearing pass owns the count write port until it finishes
   assign cnt_we    = cmd.clear_step | ex_cnt_we;
   assign cnt_waddr = cmd.clear_step ? clear_addr_ff : ex_cnt_addr;
   assign cnt_wdata = cmd.clear_step ? '0 : ex_cnt_data;

   pfa_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_FRAMES)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cmd.launch),
      .raddr (IDX_W'(req_data.frame)),
      .rdata (cnt_rd)
   );

   pfa_ram #(
      .WIDTH (14),
      .DEPTH (NUM_FRAMES)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (IDX_W'(free_total_ff)),
      .wdata (frame_ff),
      .re    (cmd.launch),
      .raddr (stk_raddr),
      .rdata (stk_rd)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/core/page_frame_alloc_refcount.sv */
// Page-frame allocator with per-frame reference counts: top level.
// Depends on pfa_pkg, pfa_ctrl, pfa_datapath (which holds two pfa_ram instances).
//
// A request is taken on a clock edge with start high and busy low. Every request
// gives exactly one result: rsp_strobe is high for one cycle with rsp_data, registered
// from the execute state, and the receiver cannot stall it. A request first does the
// registered reads of the count memory and the free stack, then updates the memories
// and the free total; a new request may be taken in the cycle its predecessor's
// result is shown. After reset busy stays high while the count memory is cleared
// one entry per cycle. csr_we writes the kernel end frame; the user must write it
// only while the block is idle, which the block itself does not enforce.
module page_frame_alloc_refcount
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES = 16384,
   parameter int COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [13:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   pfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   pfa_datapath #(
      .NUM_FRAMES (NUM_FRAMES),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for page_frame_alloc_refcount: queue-fed request driver,
// result monitor, and a frame-table predictor kept in step with the DUT.
// Depends on pfa_pkg and the page_frame_alloc_refcount RTL.
module tb_top;
   import pfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_COUNT = 16384;
   localparam logic [7:0] COUNT_TOP = 8'hFF;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [13:0] csr_wdata = '0;

   // predictor state
   logic [7:0]  ref_table [FRAME_COUNT];
   logic [13:0] free_stack [FRAME_COUNT];
   int          free_total;
   logic [13:0] kernel_end;

   req_type     req_backlog [$];
   rsp_type     due_rsp [$];
   rsp_type     want_rsp;
   int          gap_left = 0;
   bit          gaps_on = 1'b1;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   page_frame_alloc_refcount dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("page_frame_alloc_refcount: mismatch");
         $finish;
      end
   end

   // Applies one request to the frame table and returns the result it yields.
   function automatic rsp_type frame_table_update(req_type r);
      rsp_type o;
      o = '0;
      o.status = STAT_OK;
      case (r.op)
         OP_ALLOC: begin
            if (free_total == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               free_total--;
               o.alloc_frame = free_stack[free_total];
               ref_table[o.alloc_frame] = 8'd1;
               o.ref_count = 8'd1;
            end
         end
         OP_FREE, OP_SEED: begin
            if (int'(r.frame) >= FRAME_COUNT || r.frame < kernel_end) begin
               o.status = STAT_BAD;
            end else begin
               if (r.op == OP_SEED)
                  ref_table[r.frame] = '0;
               else if (ref_table[r.frame] != 0)
                  ref_table[r.frame] = ref_table[r.frame] - 8'd1;
               o.ref_count = ref_table[r.frame];
               if (o.ref_count == 0) begin
                  if (free_total >= FRAME_COUNT) begin
                     o.status = STAT_FULL;
                  end else begin
                     free_stack[free_total] = r.frame;
                     free_total++;
                  end
               end
            end
         end
         OP_UP, OP_DOWN, OP_QUERY: begin
            if (int'(r.frame) >= FRAME_COUNT) begin
               o.status = STAT_BAD;
            end else begin
               if (r.op == OP_UP && ref_table[r.frame] != COUNT_TOP)
                  ref_table[r.frame] = ref_table[r.frame] + 8'd1;
               else if (r.op == OP_DOWN && ref_table[r.frame] != 0)
                  ref_table[r.frame] = ref_table[r.frame] - 8'd1;
               o.ref_count = ref_table[r.frame];
            end
         end
         default: ;
      endcase
      o.free_count = free_total[14:0];
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // driver: start holds while busy; random idle gaps between transfers while gaps_on is set
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy)
            due_rsp.push_back(frame_table_update(req_data));
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_backlog.size() != 0 && gaps_on && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 7);
               start <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_data <= req_backlog.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (due_rsp.size() == 0) begin
            report_mismatch("result with no transfer pending, free_count",
                            rsp_data.free_count, 0);
         end else begin
            want_rsp = due_rsp.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", rsp_data.status, want_rsp.status);
            if (rsp_data.alloc_frame !== want_rsp.alloc_frame)
               report_mismatch("alloc_frame", rsp_data.alloc_frame, want_rsp.alloc_frame);
            if (rsp_data.ref_count !== want_rsp.ref_count)
               report_mismatch("ref_count", rsp_data.ref_count, want_rsp.ref_count);
            if (rsp_data.free_count !== want_rsp.free_count)
               report_mismatch("free_count", rsp_data.free_count, want_rsp.free_count);
         end
      end
   end

   task automatic queue_req(input logic [2:0] op, input logic [13:0] frame);
      req_type r;
      r.op = op;
      r.frame = frame;
      req_backlog.push_back(r);
   endtask

   // wait until every transfer has been made and every result has come back
   task automatic settle();
      do
         @(posedge clock);
      while (req_backlog.size() != 0 || start || busy || due_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_kernel_end(input logic [13:0] value);
      settle();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      kernel_end = value;
   endtask

   function automatic logic [2:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 24) return OP_ALLOC;
      if (r < 44) return OP_FREE;
      if (r < 58) return OP_SEED;
      if (r < 74) return OP_UP;
      if (r < 86) return OP_DOWN;
      if (r < 96) return OP_QUERY;
      if (r < 98) return OP_SPARE_A;
      return OP_SPARE_B;
   endfunction

   // mostly a narrow window around the kernel end, so counts and pushes collide
   function automatic logic [13:0] pick_frame(input int base);
      if ($urandom_range(0, 9) < 7)
         return 14'(base + $urandom_range(0, 31));
      return 14'($urandom_range(0, FRAME_COUNT - 1));
   endfunction

   task automatic queue_random_items(input int count);
      int base;
      int made;
      logic [13:0] f;
      base = (kernel_end >= 8) ? int'(kernel_end) - 8 : 0;
      if (base > FRAME_COUNT - 32)
         base = FRAME_COUNT - 32;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 7) == 0) begin
            // frame lifecycle: seed, hand out, share, release twice
            f = pick_frame(base);
            queue_req(OP_SEED, f);
            queue_req(OP_ALLOC, 14'($urandom()));
            queue_req(OP_UP, f);
            queue_req(OP_FREE, f);
            queue_req(OP_FREE, f);
            made += 5;
         end else begin
            queue_req(pick_op(), pick_frame(base));
            made++;
         end
      end
   endtask

   initial begin
      logic [13:0] hot;
      logic [13:0] phase_end [4];
      for (int i = 0; i < FRAME_COUNT; i++)
         ref_table[i] = '0;
      free_total = 0;
      kernel_end = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      settle();

      // directed, kernel end still at its reset value
      queue_req(OP_ALLOC, 14'd0);
      queue_req(OP_QUERY, 14'd0);
      queue_req(OP_QUERY, 14'h3FFF);
      queue_req(OP_SEED, 14'd0);
      queue_req(OP_SEED, 14'h3FFF);
      queue_req(OP_ALLOC, 14'h3FFF);
      queue_req(OP_ALLOC, 14'h3FFF);
      queue_req(OP_ALLOC, 14'd0);
      queue_req(OP_UP, 14'h3FFF);
      queue_req(OP_UP, 14'h3FFF);
      queue_req(OP_DOWN, 14'h3FFF);
      queue_req(OP_FREE, 14'h3FFF);
      queue_req(OP_FREE, 14'h3FFF);
      queue_req(OP_FREE, 14'h3FFF);   // count already zero: pushed again
      queue_req(OP_DOWN, 14'd5);
      queue_req(OP_SPARE_A, 14'h2AAA);
      queue_req(OP_SPARE_B, 14'h1555);
      queue_req(OP_ALLOC, 14'd0);
      queue_req(OP_ALLOC, 14'd0);
      settle();

      write_kernel_end(14'd100);
      queue_req(OP_SEED, 14'd99);
      queue_req(OP_FREE, 14'd99);
      queue_req(OP_SEED, 14'd100);
      queue_req(OP_UP, 14'd50);
      queue_req(OP_QUERY, 14'd50);
      queue_req(OP_FREE, 14'd0);

      // count saturation at both ends
      hot = 14'($urandom_range(0, FRAME_COUNT - 1));
      for (int i = 0; i < 258; i++)
         queue_req(OP_UP, hot);
      queue_req(OP_DOWN, hot);
      queue_req(OP_QUERY, hot);
      queue_req(OP_SEED, 14'h3FFF);
      queue_req(OP_DOWN, 14'h3FFF);
      settle();

      phase_end[0] = 14'h3FFF;
      phase_end[1] = 14'd0;
      phase_end[2] = 14'($urandom_range(1, FRAME_COUNT - 2));
      phase_end[3] = 14'd1;
      foreach (phase_end[p]) begin
         write_kernel_end(phase_end[p]);
         queue_random_items(280);
      end

      // no idling from here on
      settle();
      gaps_on = 1'b0;
      write_kernel_end(14'd0);
      queue_req(OP_SEED, 14'd5);
      queue_req(OP_UP, 14'd9);
      queue_req(OP_FREE, 14'd9);
      queue_req(OP_FREE, 14'd9);
      queue_req(OP_QUERY, 14'd9);
      queue_req(OP_ALLOC, 14'd0);
      queue_req(OP_ALLOC, 14'd0);
      queue_req(OP_SEED, 14'd5);
      queue_req(OP_SEED, 14'd6);
      queue_req(OP_ALLOC, 14'd0);
      queue_random_items(40);
      settle();

      if (mismatch_count == 0)
         $display("page_frame_alloc_refcount: match");
      else
         $display("page_frame_alloc_refcount: mismatch");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/pfa_ctrl.sv
rtl/core/pfa_datapath.sv
rtl/core/page_frame_alloc_refcount.sv
bench/tb_top.sv
